// ===== hdl/ofa_pkg.sv =====
`default_nettype none

package ofa_pkg;

    localparam int ISQRT_LAT    = 32;
    localparam int NORM_STEPS   = 7;
    localparam int DIV_BITS     = 32;
    localparam int CORDIC_STEPS = 24;
    // abs/max, normalize, square, sum, sqrt, divide, sign
    localparam int LANE_LAT  = 1 + NORM_STEPS + 2 + ISQRT_LAT + DIV_BITS + 1;
    // products, dot/cross, radicand, sqrt, pre-rotate, cordic, scale, compare
    localparam int MERGE_LAT = 3 + ISQRT_LAT + 1 + CORDIC_STEPS + 2;
    localparam int FRONT_LAT = 2;
    localparam int TOTAL_LAT = FRONT_LAT + 2 * LANE_LAT + MERGE_LAT;

    localparam logic [31:0] ONE_Q30      = 32'h4000_0000;
    localparam logic [14:0] RIGHT_ANGLE  = 15'd9000;
    localparam logic [14:0] HALF_TURN_CD = 15'd18000;

    localparam logic       REG_TOL     = 1'b0;
    localparam logic       REG_MIN_LEN = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_ORTHO = 3'd4;

    typedef logic [2:0][31:0] t_vec3;
    typedef logic [2:0][63:0] t_wvec3;

    typedef struct packed {
        logic [14:0] angle;
        logic [2:0]  status;
    } t_meas;

    // atan(2^-k) with 2^31 units per half turn
    function automatic logic signed [39:0] atan_step(input logic [4:0] k);
        logic signed [39:0] v;
        case (k)
            5'd0:  v = 40'sd536870912;
            5'd1:  v = 40'sd316933406;
            5'd2:  v = 40'sd167458907;
            5'd3:  v = 40'sd85004756;
            5'd4:  v = 40'sd42667331;
            5'd5:  v = 40'sd21354465;
            5'd6:  v = 40'sd10679838;
            5'd7:  v = 40'sd5340245;
            5'd8:  v = 40'sd2670163;
            5'd9:  v = 40'sd1335087;
            5'd10: v = 40'sd667544;
            5'd11: v = 40'sd333772;
            5'd12: v = 40'sd166886;
            5'd13: v = 40'sd83443;
            5'd14: v = 40'sd41722;
            5'd15: v = 40'sd20861;
            5'd16: v = 40'sd10430;
            5'd17: v = 40'sd5215;
            5'd18: v = 40'sd2608;
            5'd19: v = 40'sd1304;
            5'd20: v = 40'sd652;
            5'd21: v = 40'sd326;
            5'd22: v = 40'sd163;
            5'd23: v = 40'sd81;
            default: v = 40'sd0;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ofa_isqrt.sv =====
`default_nettype none

// Floor square root of a 64-bit value, one result bit per stage.
module ofa_isqrt #(
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [63:0]   i_rad,
    input  logic [PW-1:0] i_pay,
    output logic [31:0]   o_root,
    output logic [PW-1:0] o_pay
);
    import ofa_pkg::*;

    logic [63:0]   r_rem  [ISQRT_LAT];
    logic [63:0]   r_root [ISQRT_LAT];
    logic [PW-1:0] r_pay  [ISQRT_LAT];
    logic [63:0]   n_rem  [ISQRT_LAT];
    logic [63:0]   n_root [ISQRT_LAT];

    always_comb begin
        logic [63:0] rem_in;
        logic [63:0] root_in;
        logic [63:0] bitv;
        logic [63:0] trial;
        for (int k = 0; k < ISQRT_LAT; k++) begin
            rem_in  = (k == 0) ? i_rad : r_rem[k-1];
            root_in = (k == 0) ? 64'd0 : r_root[k-1];
            bitv    = 64'd1 << (62 - 2 * k);
            trial   = root_in + bitv;
            if (rem_in >= trial) begin
                n_rem[k]  = rem_in - trial;
                n_root[k] = (root_in >> 1) + bitv;
            end else begin
                n_rem[k]  = rem_in;
                n_root[k] = root_in >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < ISQRT_LAT; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_pay[k]  <= (k == 0) ? i_pay : r_pay[k-1];
            end
        end
    end

    assign o_root = r_root[ISQRT_LAT-1][31:0];
    assign o_pay  = r_pay[ISQRT_LAT-1];

endmodule

`default_nettype wire

// ===== hdl/ofa_unit_lane.sv =====
`default_nettype none

// Scales one 3-vector to unit length, Q1.30 out.
module ofa_unit_lane #(
    parameter int PW = 1
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  ofa_pkg::t_wvec3        i_vec,
    input  logic [PW-1:0]          i_pay,
    output ofa_pkg::t_vec3         o_unit,
    output logic [PW-1:0]          o_pay
);
    import ofa_pkg::*;

    localparam int SW = PW + 4;   // {pay, zero, signs}
    localparam int QW = SW + 96;  // side plus normalized magnitudes

    // magnitude stage
    logic [63:0]   r_m0  [3];
    logic [63:0]   r_mx0;
    logic [SW-1:0] r_sd0;

    // normalize stages
    logic [63:0]   r_nm  [NORM_STEPS][3];
    logic [63:0]   r_nmx [NORM_STEPS];
    logic [SW-1:0] r_nsd [NORM_STEPS];
    logic [63:0]   n_nm  [NORM_STEPS][3];
    logic [63:0]   n_nmx [NORM_STEPS];

    // square and sum
    logic [63:0]   r_sq  [3];
    logic [31:0]   r_qm  [3];
    logic [SW-1:0] r_qsd;
    logic [63:0]   r_sum;
    logic [31:0]   r_sm  [3];
    logic [SW-1:0] r_ssd;

    logic [31:0]   sq_root;
    logic [QW-1:0] sq_pay_in;
    logic [QW-1:0] sq_pay_out;
    logic [SW-1:0] sq_sd;
    logic [31:0]   sq_m [3];

    // divide stages
    logic [63:0]   r_rm  [DIV_BITS][3];
    logic [31:0]   r_q   [DIV_BITS][3];
    logic [31:0]   r_dr  [DIV_BITS];
    logic [SW-1:0] r_dsd [DIV_BITS];
    logic [63:0]   n_rm  [DIV_BITS][3];
    logic [31:0]   n_q   [DIV_BITS][3];

    t_vec3         r_u;
    logic [PW-1:0] r_opay;

    logic [63:0] m_in [3];
    logic [63:0] mx_in;

    always_comb begin
        mx_in = 64'd0;
        for (int i = 0; i < 3; i++) begin
            m_in[i] = mag64(i_vec[i]);
            if (m_in[i] > mx_in) begin
                mx_in = m_in[i];
            end
        end
    end

    // shift all three together until the largest lies in [2^30, 2^31]
    always_comb begin
        logic [63:0] src_mx;
        logic [63:0] src_m [3];
        int          amt;
        logic        rt;
        logic        lf;
        for (int j = 0; j < NORM_STEPS; j++) begin
            src_mx = (j == 0) ? r_mx0 : r_nmx[j-1];
            for (int i = 0; i < 3; i++) begin
                src_m[i] = (j == 0) ? r_m0[i] : r_nm[j-1][i];
            end
            if (j < NORM_STEPS - 1) begin
                amt = 32 >> j;
                rt  = (src_mx > 64'h8000_0000) && ((src_mx >> amt) > 64'h8000_0000);
                lf  = (src_mx < 64'h4000_0000) && ((src_mx << amt) < 64'h4000_0000);
            end else begin
                amt = 1;
                rt  = src_mx > 64'h8000_0000;
                lf  = src_mx < 64'h4000_0000;
            end
            if (rt) begin
                n_nmx[j] = src_mx >> amt;
                for (int i = 0; i < 3; i++) n_nm[j][i] = src_m[i] >> amt;
            end else if (lf) begin
                n_nmx[j] = src_mx << amt;
                for (int i = 0; i < 3; i++) n_nm[j][i] = src_m[i] << amt;
            end else begin
                n_nmx[j] = src_mx;
                for (int i = 0; i < 3; i++) n_nm[j][i] = src_m[i];
            end
        end
    end

    assign sq_pay_in = {r_ssd, r_sm[2], r_sm[1], r_sm[0]};
    assign {sq_sd, sq_m[2], sq_m[1], sq_m[0]} = sq_pay_out;

    ofa_isqrt #(
        .PW (QW)
    ) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rad  (r_sum),
        .i_pay  (sq_pay_in),
        .o_root (sq_root),
        .o_pay  (sq_pay_out)
    );

    // restoring divide, quotient bit 31-k in stage k
    always_comb begin
        logic [63:0] rem_in;
        logic [31:0] q_in;
        logic [31:0] r_in;
        logic [63:0] dv;
        for (int k = 0; k < DIV_BITS; k++) begin
            r_in = (k == 0) ? sq_root : r_dr[k-1];
            dv   = {32'd0, r_in} << (DIV_BITS - 1 - k);
            for (int i = 0; i < 3; i++) begin
                rem_in = (k == 0) ? (({32'd0, sq_m[i]} << 30) + {33'd0, sq_root[31:1]})
                                  : r_rm[k-1][i];
                q_in   = (k == 0) ? 32'd0 : r_q[k-1][i];
                if (rem_in >= dv) begin
                    n_rm[k][i] = rem_in - dv;
                    n_q[k][i]  = q_in | (32'd1 << (DIV_BITS - 1 - k));
                end else begin
                    n_rm[k][i] = rem_in;
                    n_q[k][i]  = q_in;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_m0[i] <= m_in[i];
            end
            r_mx0 <= mx_in;
            r_sd0 <= {i_pay, (mx_in == 64'd0), i_vec[2][63], i_vec[1][63], i_vec[0][63]};

            for (int j = 0; j < NORM_STEPS; j++) begin
                r_nmx[j] <= n_nmx[j];
                r_nsd[j] <= (j == 0) ? r_sd0 : r_nsd[j-1];
                for (int i = 0; i < 3; i++) r_nm[j][i] <= n_nm[j][i];
            end

            for (int i = 0; i < 3; i++) begin
                r_qm[i] <= r_nm[NORM_STEPS-1][i][31:0];
                r_sq[i] <= r_nm[NORM_STEPS-1][i][31:0] * r_nm[NORM_STEPS-1][i][31:0];
                r_sm[i] <= r_qm[i];
            end
            r_qsd <= r_nsd[NORM_STEPS-1];
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
            r_ssd <= r_qsd;

            for (int k = 0; k < DIV_BITS; k++) begin
                r_dr[k]  <= (k == 0) ? sq_root : r_dr[k-1];
                r_dsd[k] <= (k == 0) ? sq_sd : r_dsd[k-1];
                for (int i = 0; i < 3; i++) begin
                    r_rm[k][i] <= n_rm[k][i];
                    r_q[k][i]  <= n_q[k][i];
                end
            end

            for (int i = 0; i < 3; i++) begin
                if (r_dsd[DIV_BITS-1][3]) begin
                    r_u[i] <= 32'd0;
                end else if (r_dsd[DIV_BITS-1][i]) begin
                    r_u[i] <= (r_q[DIV_BITS-1][i] > ONE_Q30) ? (~ONE_Q30 + 32'd1)
                                                             : (~r_q[DIV_BITS-1][i] + 32'd1);
                end else begin
                    r_u[i] <= (r_q[DIV_BITS-1][i] > ONE_Q30) ? ONE_Q30 : r_q[DIV_BITS-1][i];
                end
            end
            r_opay <= r_dsd[DIV_BITS-1][SW-1:4];
        end
    end

    assign o_unit = r_u;
    assign o_pay  = r_opay;

endmodule

`default_nettype wire

// ===== hdl/ofa_merge.sv =====
`default_nettype none

// Combines the two unit lanes: dot and cross products, arccos by CORDIC,
// and the right-angle test.
module ofa_merge (
    input  logic            i_clk,
    input  logic            i_en,
    input  ofa_pkg::t_vec3  i_xu,
    input  ofa_pkg::t_vec3  i_yu,
    input  logic [1:0]      i_zl,
    input  logic [13:0]     i_tol,
    output ofa_pkg::t_vec3  o_xu,
    output ofa_pkg::t_vec3  o_yu,
    output ofa_pkg::t_wvec3 o_zv,
    output ofa_pkg::t_meas  o_meas
);
    import ofa_pkg::*;

    localparam int CW = 2 + 192 + 96 + 96;  // {zero flags, cross, y, x}
    localparam int IW = CW + 32;            // plus cosine

    logic signed [63:0] r_pd [3];
    logic signed [63:0] r_pc [6];
    logic [CW-1-192:0]  r_psd;   // {zero flags, y, x}

    logic signed [31:0] r_c;
    t_wvec3             r_zv;
    logic [CW-1-192:0]  r_dsd;

    logic [63:0]        r_rad;
    logic signed [31:0] r_rc;
    logic [CW-1:0]      r_rsd;

    logic [31:0]        sq_root;
    logic [IW-1:0]      sq_pay_out;
    logic signed [31:0] sq_c;
    logic [CW-1:0]      sq_sd;

    logic signed [39:0] r_cx [CORDIC_STEPS+1];
    logic signed [39:0] r_cy [CORDIC_STEPS+1];
    logic signed [39:0] r_ca [CORDIC_STEPS+1];
    logic [CW-1:0]      r_csd [CORDIC_STEPS+1];
    logic signed [39:0] n_cx [CORDIC_STEPS];
    logic signed [39:0] n_cy [CORDIC_STEPS];
    logic signed [39:0] n_ca [CORDIC_STEPS];

    logic [46:0]        r_prod;
    logic [CW-1:0]      r_msd;

    t_vec3              r_oxu;
    t_vec3              r_oyu;
    t_wvec3             r_ozv;
    t_meas              r_meas;

    logic signed [63:0] dot_sum;
    logic signed [63:0] dot_q;
    logic signed [31:0] dot_c;
    logic signed [63:0] csq;
    logic [31:0]        a_clamp;
    logic [46:0]        rnd;
    logic [14:0]        ang;
    logic [14:0]        dev;
    logic [1:0]         fin_zl;

    always_comb begin
        dot_sum = r_pd[0] + r_pd[1] + r_pd[2] + 64'sd536870912;
        dot_q   = dot_sum >>> 30;
        if (dot_q > 64'sd1073741824) begin
            dot_c = 32'sd1073741824;
        end else if (dot_q < -64'sd1073741824) begin
            dot_c = -32'sd1073741824;
        end else begin
            dot_c = dot_q[31:0];
        end
        csq = r_c * r_c;
    end

    assign {sq_sd, sq_c} = sq_pay_out;

    ofa_isqrt #(
        .PW (IW)
    ) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rad  (r_rad),
        .i_pay  ({r_rsd, r_rc}),
        .o_root (sq_root),
        .o_pay  (sq_pay_out)
    );

    always_comb begin
        logic signed [39:0] dx;
        logic signed [39:0] dy;
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            dx = r_cy[k] >>> k;
            dy = r_cx[k] >>> k;
            if (!r_cy[k][39]) begin
                n_cx[k] = r_cx[k] + dx;
                n_cy[k] = r_cy[k] - dy;
                n_ca[k] = r_ca[k] + atan_step(5'(k));
            end else begin
                n_cx[k] = r_cx[k] - dx;
                n_cy[k] = r_cy[k] + dy;
                n_ca[k] = r_ca[k] - atan_step(5'(k));
            end
        end
    end

    always_comb begin
        logic signed [39:0] a_end;
        a_end = r_ca[CORDIC_STEPS];
        if (a_end[39]) begin
            a_clamp = 32'd0;
        end else if (a_end > 40'sh0080000000) begin
            a_clamp = 32'h8000_0000;
        end else begin
            a_clamp = a_end[31:0];
        end
        rnd    = r_prod + 47'h0000_4000_0000;
        ang    = rnd[45:31];
        dev    = (ang >= RIGHT_ANGLE) ? (ang - RIGHT_ANGLE) : (RIGHT_ANGLE - ang);
        fin_zl = r_msd[CW-1:CW-2];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pd[0] <= $signed(i_xu[0]) * $signed(i_yu[0]);
            r_pd[1] <= $signed(i_xu[1]) * $signed(i_yu[1]);
            r_pd[2] <= $signed(i_xu[2]) * $signed(i_yu[2]);
            r_pc[0] <= $signed(i_xu[1]) * $signed(i_yu[2]);
            r_pc[1] <= $signed(i_xu[2]) * $signed(i_yu[1]);
            r_pc[2] <= $signed(i_xu[2]) * $signed(i_yu[0]);
            r_pc[3] <= $signed(i_xu[0]) * $signed(i_yu[2]);
            r_pc[4] <= $signed(i_xu[0]) * $signed(i_yu[1]);
            r_pc[5] <= $signed(i_xu[1]) * $signed(i_yu[0]);
            r_psd   <= {i_zl, i_yu, i_xu};

            r_c     <= dot_c;
            r_zv[0] <= r_pc[0] - r_pc[1];
            r_zv[1] <= r_pc[2] - r_pc[3];
            r_zv[2] <= r_pc[4] - r_pc[5];
            r_dsd   <= r_psd;

            r_rad <= 64'h1000_0000_0000_0000 - csq;
            r_rc  <= r_c;
            r_rsd <= {r_dsd[CW-193:CW-194], r_zv, r_dsd[191:0]};

            // negative cosine: pre-rotate by a quarter turn
            if (sq_c[31]) begin
                r_cx[0] <= {8'd0, sq_root};
                r_cy[0] <= -{{8{sq_c[31]}}, sq_c};
                r_ca[0] <= 40'sd1073741824;
            end else begin
                r_cx[0] <= {{8{sq_c[31]}}, sq_c};
                r_cy[0] <= {8'd0, sq_root};
                r_ca[0] <= 40'sd0;
            end
            r_csd[0] <= sq_sd;
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_cx[k+1]  <= n_cx[k];
                r_cy[k+1]  <= n_cy[k];
                r_ca[k+1]  <= n_ca[k];
                r_csd[k+1] <= r_csd[k];
            end

            r_prod <= a_clamp * HALF_TURN_CD;
            r_msd  <= r_csd[CORDIC_STEPS];

            r_oxu <= r_msd[95:0];
            r_oyu <= r_msd[191:96];
            r_ozv <= r_msd[383:192];
            if (fin_zl != 2'd0) begin
                r_meas.angle  <= 15'd0;
                r_meas.status <= {1'b0, fin_zl};
            end else begin
                r_meas.angle  <= ang;
                r_meas.status <= (dev > {1'b0, i_tol}) ? ST_NOT_ORTHO : ST_OK;
            end
        end
    end

    assign o_xu   = r_oxu;
    assign o_yu   = r_oyu;
    assign o_zv   = r_ozv;
    assign o_meas = r_meas;

endmodule

`default_nettype wire

// ===== hdl/orthonormal_frame_from_axes_core.sv =====
`default_nettype none

// Channel   Dir  Width  Contents
// s_axis    in   192    xdir_x, xdir_y, xdir_z, ydir_x, ydir_y, ydir_z (32 bit each)
// m_axis    out  312    ux_*, uy_*, uz_* (32 bit each), angle_centideg (15), status (3)
// cfg       in   16     index 0 tolerance_centideg, index 1 min_length
//
// One beat accepted per cycle while the skid entry is empty; each beat passes through the
// length test, the X and Y lanes in parallel, the merge and the Z lane.
// The depth is set by the three bit-per-stage square roots and the two dividers.
// Reset is synchronous; it sets tolerance 500 and minimum length 1, clears the valid chain and output valids.
// A stall on m_axis freezes the pipe once the two-entry output buffer fills.
module orthonormal_frame_from_axes_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,   // xdir_x, xdir_y, xdir_z, ydir_x, ydir_y, ydir_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [311:0] m_axis_tdata,   // ux_x..uz_z, angle_centideg, status, zero pad
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [15:0]  i_cfg_wdata
);
    import ofa_pkg::*;

    logic [13:0]  r_tol;
    logic [15:0]  r_min_len;

    logic         en;
    logic [TOTAL_LAT-1:0] r_vld;

    // length test
    t_vec3        r_fx, r_fy;
    logic [63:0]  r_fsq [6];
    logic [31:0]  r_ml2;
    t_vec3        r_lx, r_ly;
    logic [1:0]   r_zl;
    logic [63:0]  sum_x, sum_y;

    t_wvec3       lx_w, ly_w;
    t_vec3        xu, yu;
    logic         x_zl, y_zl;

    t_vec3        m_xu, m_yu;
    t_wvec3       m_zv;
    t_meas        m_meas;

    t_vec3        zu;
    logic [209:0] z_pay;
    t_vec3        z_xu, z_yu;
    t_meas        z_meas;
    logic [311:0] pipe_data;

    logic         r_out_v, r_skid_v;
    logic [311:0] r_out, r_skid;
    logic         take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol     <= 14'd500;
            r_min_len <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TOL:     r_tol     <= i_cfg_wdata[13:0];
                REG_MIN_LEN: r_min_len <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign en            = !r_skid_v;
    assign s_axis_tready = en;

    always_comb begin
        sum_x = r_fsq[0] + r_fsq[1] + r_fsq[2];
        sum_y = r_fsq[3] + r_fsq[4] + r_fsq[5];
        for (int i = 0; i < 3; i++) begin
            lx_w[i] = {{32{r_lx[i][31]}}, r_lx[i]};
            ly_w[i] = {{32{r_ly[i][31]}}, r_ly[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_fx[i]     <= s_axis_tdata[32*i +: 32];
                r_fy[i]     <= s_axis_tdata[96 + 32*i +: 32];
                r_fsq[i]    <= $signed(s_axis_tdata[32*i +: 32])
                               * $signed(s_axis_tdata[32*i +: 32]);
                r_fsq[3+i]  <= $signed(s_axis_tdata[96 + 32*i +: 32])
                               * $signed(s_axis_tdata[96 + 32*i +: 32]);
            end
            r_ml2 <= r_min_len * r_min_len;
            r_lx  <= r_fx;
            r_ly  <= r_fy;
            // all-zero vector is rejected even with a zero minimum
            r_zl[0] <= (sum_x == 64'd0) || (sum_x < {32'd0, r_ml2});
            r_zl[1] <= (sum_y == 64'd0) || (sum_y < {32'd0, r_ml2});
        end
    end

    ofa_unit_lane #(
        .PW (1)
    ) u_lane_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_vec  (lx_w),
        .i_pay  (r_zl[0]),
        .o_unit (xu),
        .o_pay  (x_zl)
    );

    ofa_unit_lane #(
        .PW (1)
    ) u_lane_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_vec  (ly_w),
        .i_pay  (r_zl[1]),
        .o_unit (yu),
        .o_pay  (y_zl)
    );

    ofa_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_xu   (xu),
        .i_yu   (yu),
        .i_zl   ({y_zl, x_zl}),
        .i_tol  (r_tol),
        .o_xu   (m_xu),
        .o_yu   (m_yu),
        .o_zv   (m_zv),
        .o_meas (m_meas)
    );

    ofa_unit_lane #(
        .PW (210)
    ) u_lane_z (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_vec  (m_zv),
        .i_pay  ({m_meas, m_yu, m_xu}),
        .o_unit (zu),
        .o_pay  (z_pay)
    );

    assign {z_meas, z_yu, z_xu} = z_pay;

    always_comb begin
        if (z_meas.status != ST_OK) begin
            pipe_data[287:0] = 288'd0;
        end else begin
            pipe_data[287:0] = {zu, z_yu, z_xu};
        end
        pipe_data[302:288] = z_meas.angle;
        pipe_data[305:303] = z_meas.status;
        pipe_data[311:306] = 6'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], s_axis_tvalid};
        end
    end

    assign take = r_out_v && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (en && r_vld[TOTAL_LAT-1]) begin
            if (!r_out_v || take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_out_v  <= r_skid_v;
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_vld[TOTAL_LAT-1]) begin
            if (!r_out_v || take) begin
                r_out <= pipe_data;
            end else begin
                r_skid <= pipe_data;
            end
        end else if (take && r_skid_v) begin
            r_out <= r_skid;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;

endmodule

`default_nettype wire

// ===== hdl/ofa_checker.sv =====
`default_nettype none

module ofa_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [311:0] m_axis_tdata
);
    import ofa_pkg::*;

    logic [2:0]  st;
    logic [14:0] ang;

    assign st  = m_axis_tdata[305:303];
    assign ang = m_axis_tdata[302:288];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> st <= ST_NOT_ORTHO)
        else $error("status code out of range");

    a_axes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && st != ST_OK |-> m_axis_tdata[287:0] == 288'd0)
        else $error("axes not cleared on error");

    // zero-length codes lie between ok and not orthogonal
    a_angle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && st != ST_OK && st != ST_NOT_ORTHO |-> ang == 15'd0)
        else $error("angle set on zero-length input");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ang <= HALF_TURN_CD)
        else $error("angle above half turn");

endmodule

bind orthonormal_frame_from_axes_core ofa_checker u_ofa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
